// ===== hdl/gfrmx_pkg.sv =====
// gfrmx_pkg: shared constants for the gf region multiply-xor core
// field width mode codes, reduction polynomials, configuration register indexes
// no dependencies
package gfrmx_pkg;

  localparam int WORD_W = 32;
  localparam int MODE_W = 2;
  localparam int CFG_IDX_W = 2;

  // field width mode codes (mode 3 decodes as the 32-bit field)
  localparam logic [MODE_W-1:0] MODE_GF8  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GF16 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GF32 = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COEF = 2'd1;

  // reduction polynomials without the leading x^w term
  localparam logic [7:0]  POLY_W8  = 8'h1D;
  localparam logic [15:0] POLY_W16 = 16'h100B;
  localparam logic [31:0] POLY_W32 = 32'h0040_0007;

  localparam logic [MODE_W-1:0]  MODE_RESET = MODE_GF8;
  localparam logic [WORD_W-1:0]  COEF_RESET = 32'h0000_0001;

endpackage

// ===== hdl/gf_region_multiply_xor_core.sv =====
// gf_region_multiply_xor_core: gf(2^8/16/32) region multiply-xor, one 32-bit word per beat
// pipeline: each input beat is held in the product register, then in the output register, before result valid
// throughput: one beat per cycle while out_ready_i is high; lane multipliers fully pipelined
// reset: asynchronous active low, clears both pipeline valids, mode to gf(2^8), coefficient to 1
// depends on gfrmx_pkg, gfrmx_lane, gfrmx_merge
module gf_region_multiply_xor_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gfrmx_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gfrmx_pkg::WORD_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [31:0]                     source_word_i,
  input  logic [31:0]                     target_word_i,
  input  logic                            last_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [31:0]                     new_target_o,
  output logic                            last_out_o
);

  logic [gfrmx_pkg::MODE_W-1:0] mode_d, mode_q;
  logic [gfrmx_pkg::WORD_W-1:0] coef_d, coef_q;

  always_comb begin
    mode_d = mode_q;
    coef_d = coef_q;
    if (cfg_we_i) begin
      if (cfg_idx_i == gfrmx_pkg::CFG_IDX_MODE) begin
        mode_d = cfg_data_i[gfrmx_pkg::MODE_W-1:0];
      end else if (cfg_idx_i == gfrmx_pkg::CFG_IDX_COEF) begin
        coef_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= gfrmx_pkg::MODE_RESET;
      coef_q <= gfrmx_pkg::COEF_RESET;
    end else begin
      mode_q <= mode_d;
      coef_q <= coef_d;
    end
  end

  // pipeline handshake
  logic s1_valid_q, s2_valid_q;
  logic s1_ready, s2_ready;
  logic s1_load, s2_load;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s1_load    = in_valid_i && s1_ready;
  assign s2_load    = s1_valid_q && s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1 side payload
  logic [31:0] tgt1_q;
  logic        last1_q;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      tgt1_q  <= target_word_i;
      last1_q <= last_word_i;
    end
  end

  // lanes for all three widths run in parallel on the same word
  logic [3:0][7:0]  res8;
  logic [1:0][15:0] res16;
  logic [31:0]      res32;

  for (genvar g = 0; g < 4; g++) begin : g_lane8
    gfrmx_lane #(
      .W    (8),
      .POLY (gfrmx_pkg::POLY_W8)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (s1_load),
      .coef_i (coef_q[7:0]),
      .src_i  (source_word_i[g*8 +: 8]),
      .res_o  (res8[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_lane16
    gfrmx_lane #(
      .W    (16),
      .POLY (gfrmx_pkg::POLY_W16)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (s1_load),
      .coef_i (coef_q[15:0]),
      .src_i  (source_word_i[g*16 +: 16]),
      .res_o  (res16[g])
    );
  end

  gfrmx_lane #(
    .W    (32),
    .POLY (gfrmx_pkg::POLY_W32)
  ) u_lane32 (
    .clk_i  (clk_i),
    .en_i   (s1_load),
    .coef_i (coef_q),
    .src_i  (source_word_i),
    .res_o  (res32)
  );

  logic [31:0] merged;

  gfrmx_merge u_merge (
    .mode_i       (mode_q),
    .res8_i       (res8),
    .res16_i      (res16),
    .res32_i      (res32),
    .target_i     (tgt1_q),
    .new_target_o (merged)
  );

  // output register
  logic [31:0] out_d, out_q;
  logic        last_d, last_q;

  always_comb begin
    out_d  = out_q;
    last_d = last_q;
    if (s2_load) begin
      out_d  = merged;
      last_d = last1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign out_valid_o  = s2_valid_q;
  assign new_target_o = out_q;
  assign last_out_o   = last_q;

endmodule

// ===== hdl/gfrmx_lane.sv =====
// gfrmx_lane: one gf(2^w) multiply lane, carry-less product registered, then reduction
// reduction uses an elaboration-time table of x^(w+j) mod p
// depends on gfrmx_pkg for default polynomial
module gfrmx_lane #(
  parameter int          W    = 8,
  parameter logic [W-1:0] POLY = gfrmx_pkg::POLY_W8
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] coef_i,
  input  logic [W-1:0] src_i,
  output logic [W-1:0] res_o
);

  localparam int PW = 2 * W - 1;

  // remainder of x^(W+j) modulo the field polynomial, j = 0 .. W-2
  function automatic logic [W-2:0][W-1:0] rem_table();
    logic [W-2:0][W-1:0] tab;
    logic [W-1:0]        r;
    logic                high;
    tab = '0;
    r   = POLY;
    for (int j = 0; j < W - 1; j++) begin
      tab[j] = r;
      high   = r[W-1];
      r      = r << 1;
      if (high) begin
        r = r ^ POLY;
      end
    end
    return tab;
  endfunction

  localparam logic [W-2:0][W-1:0] REM = rem_table();

  logic [PW-1:0] prod_d;
  logic [PW-1:0] prod_q;

  // carry-less product: xor of shifted partial products
  always_comb begin
    prod_d = '0;
    for (int i = 0; i < W; i++) begin
      if (src_i[i]) begin
        prod_d = prod_d ^ ({{(W-1){1'b0}}, coef_i} << i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // fold each high product bit back in through its remainder
  always_comb begin
    res_o = prod_q[W-1:0];
    for (int j = 0; j < W - 1; j++) begin
      if (prod_q[W+j]) begin
        res_o = res_o ^ REM[j];
      end
    end
  end

endmodule

// ===== hdl/gfrmx_merge.sv =====
// gfrmx_merge: picks the lane results for the active field width and xors the target
// combinational, sits in front of the output register
// depends on gfrmx_pkg
module gfrmx_merge (
  input  logic [gfrmx_pkg::MODE_W-1:0] mode_i,
  input  logic [3:0][7:0]              res8_i,
  input  logic [1:0][15:0]             res16_i,
  input  logic [31:0]                  res32_i,
  input  logic [31:0]                  target_i,
  output logic [31:0]                  new_target_o
);

  logic [31:0] prod;

  always_comb begin
    unique case (mode_i)
      gfrmx_pkg::MODE_GF8:  prod = res8_i;
      gfrmx_pkg::MODE_GF16: prod = res16_i;
      default:              prod = res32_i;
    endcase
    new_target_o = target_i ^ prod;
  end

endmodule

// ===== tb/gf_region_multiply_xor_core_tb.sv =====
// gf_region_multiply_xor_core_tb: self-checking bench for the gf(2^w) region multiply-xor core
// a queue-fed driver, a result monitor and a bit-level predictor of the lane products
// depends on gfrmx_pkg and gf_region_multiply_xor_core
`timescale 1ns / 1ps

module gf_region_multiply_xor_core_tb;
  import gfrmx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_3 = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_GF32_ALIAS = 2'd3;
  localparam int RANDOM_WORDS = 1530;
  localparam int HOLD_CYCLES  = 64;
  localparam int STALL_LIMIT  = 2000;
  localparam int PRINT_LIMIT  = 30;

  typedef struct {
    logic [31:0] src;
    logic [31:0] tgt;
    logic        last;
  } region_word_t;

  typedef struct {
    logic [31:0] new_target;
    logic        last;
  } word_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_IDX_MODE;
  logic [WORD_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [31:0]          source_word_i = '0;
  logic [31:0]          target_word_i = '0;
  logic                 last_word_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [31:0]          new_target_o;
  logic                 last_out_o;

  // settings as the core holds them, updated only while it is idle
  logic [MODE_W-1:0] field_mode = MODE_RESET;
  logic [WORD_W-1:0] coef_value = COEF_RESET;

  region_word_t word_pending_q[$];
  word_result_t result_expect_q[$];

  int in_gap_max = 0;
  int out_gap_max = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int mismatch_count = 0;

  gf_region_multiply_xor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .source_word_i (source_word_i),
    .target_word_i (target_word_i),
    .last_word_i   (last_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .new_target_o  (new_target_o),
    .last_out_o    (last_out_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] lane_mask(logic [MODE_W-1:0] mode);
    case (mode)
      MODE_GF8:  return 32'h0000_00FF;
      MODE_GF16: return 32'h0000_FFFF;
      default:   return 32'hFFFF_FFFF;
    endcase
  endfunction

  // shift-and-add product in gf(2^w), poly given without the x^w term
  function automatic logic [31:0] gf_mul(logic [31:0] a, logic [31:0] b, int w,
                                         logic [31:0] poly, logic [31:0] mask);
    logic [31:0] acc;
    logic [31:0] top;
    logic        carry;
    acc = '0;
    top = 32'd1 << (w - 1);
    a &= mask;
    b &= mask;
    poly &= mask;
    for (int i = 0; i < w; i++) begin
      if (b[i]) acc ^= a;
      carry = |(a & top);
      a = (a << 1) & mask;
      if (carry) a ^= poly;
    end
    return acc & mask;
  endfunction

  function automatic logic [31:0] predict_new_target(logic [31:0] src, logic [31:0] tgt);
    int          w;
    logic [31:0] poly;
    logic [31:0] mask;
    logic [31:0] prod;
    logic [31:0] lane;
    case (field_mode)
      MODE_GF8: begin
        w = 8;
        poly = {24'h0, POLY_W8};
      end
      MODE_GF16: begin
        w = 16;
        poly = {16'h0, POLY_W16};
      end
      // the spare mode code decodes as the 32-bit field
      default: begin
        w = 32;
        poly = POLY_W32;
      end
    endcase
    mask = lane_mask(field_mode);
    prod = '0;
    for (int k = 0; k < 32 / w; k++) begin
      lane = (src >> (k * w)) & mask;
      prod |= gf_mul(coef_value, lane, w, poly, mask) << (k * w);
    end
    return tgt ^ prod;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // sender: one beat offered at a time, random gap after each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin : word_driver
    region_word_t nxt;
    int           in_gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o)
        result_expect_q.push_back('{predict_new_target(source_word_i, target_word_i),
                                    last_word_i});
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (word_pending_q.size() != 0) begin
          nxt = word_pending_q.pop_front();
          in_valid_i <= 1'b1;
          source_word_i <= nxt.src;
          target_word_i <= nxt.tgt;
          last_word_i <= nxt.last;
          in_gap = $urandom_range(0, in_gap_max);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each beat, stalls at random, and runs the long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    word_result_t exp_res;
    int           out_stall;
    int           hold_left;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_expect_q.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected, new_target=%h", new_target_o));
        end else begin
          exp_res = result_expect_q.pop_front();
          if (new_target_o !== exp_res.new_target)
            report_mismatch($sformatf("new_target %h, expected %h",
                                      new_target_o, exp_res.new_target));
          if (last_out_o !== exp_res.last)
            report_mismatch($sformatf("last_out %b, expected %b", last_out_o, exp_res.last));
        end
        out_stall = $urandom_range(0, out_gap_max);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_asks != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_word(input logic [31:0] src, input logic [31:0] tgt, input logic last);
    word_pending_q.push_back('{src, tgt, last});
  endtask

  // wait until every offered beat has come back, then let the pipeline drain
  task automatic settle();
    while (word_pending_q.size() != 0 || in_valid_i || result_expect_q.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IDX_MODE) field_mode = data[MODE_W-1:0];
    else if (idx == CFG_IDX_COEF) coef_value = data;
  endtask

  task automatic begin_phase(input logic [MODE_W-1:0] mode, input logic [31:0] coef,
                             input int in_max, input int out_max, input bit spare_writes);
    settle();
    // writes to unused indexes must leave both registers alone
    if (spare_writes) begin
      write_reg(CFG_IDX_SPARE_2, $urandom);
      write_reg(CFG_IDX_SPARE_3, $urandom);
    end
    // junk above the mode field is dropped by the core
    write_reg(CFG_IDX_MODE, (32'($urandom) & ~32'h3) | 32'(mode));
    write_reg(CFG_IDX_COEF, coef);
    in_gap_max = in_max;
    out_gap_max = out_max;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_coef(logic [MODE_W-1:0] mode);
    logic [31:0] m;
    m = lane_mask(mode);
    case ($urandom_range(0, 5))
      0: return $urandom & ~m;             // zero within the field
      1: return 32'd1 | ($urandom & ~m);   // unit coefficient
      2: return 32'hFFFF_FFFF;
      3: return m ^ (m >> 1);              // top bit of the lane only
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic [MODE_W-1:0] modes[4];
    logic [MODE_W-1:0] mode;
    int                total;
    int                n;
    int                phase;
    modes = '{MODE_GF8, MODE_GF16, MODE_GF32, MODE_GF32_ALIAS};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);

    // reset settings: gf(2^8) with unit coefficient, so target ^ source
    push_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_word(32'h8080_8080, 32'h1234_5678, 1'b1);

    // zero coefficient in the low byte, junk above it
    begin_phase(MODE_GF8, 32'hFFFF_FF00, 3, 3, 1'b0);
    push_word(32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0);
    push_word(32'h1234_5678, 32'h0000_0000, 1'b1);

    begin_phase(MODE_GF16, 32'h0000_FFFF, 3, 3, 1'b0);
    push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_word(32'h8000_8000, 32'hFFFF_FFFF, 1'b1);

    begin_phase(MODE_GF16, 32'h1234_0000, 0, 0, 1'b0);
    push_word(32'hCAFE_F00D, 32'h5A5A_0F0F, 1'b1);

    begin_phase(MODE_GF32, 32'hFFFF_FFFF, 0, 3, 1'b0);
    push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_word(32'h8000_0000, 32'h0000_0000, 1'b1);
    push_word(32'h0000_0001, 32'h0000_0000, 1'b0);

    // spare mode code behaves as gf(2^32)
    begin_phase(MODE_GF32_ALIAS, 32'h8000_0000, 3, 0, 1'b0);
    push_word(32'h8000_0000, 32'h0000_0000, 1'b0);
    push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    begin_phase(MODE_GF32, 32'h0000_0000, 3, 3, 1'b1);
    push_word(32'hDEAD_BEEF, 32'h0123_4567, 1'b1);
    push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);

    total = 0;
    phase = 0;
    while (total < RANDOM_WORDS) begin
      n = $urandom_range(30, 90);
      mode = modes[$urandom_range(0, 3)];
      begin_phase(mode, pick_coef(mode),
                  ($urandom_range(0, 3) == 0) ? 0 : 3,
                  ($urandom_range(0, 3) == 0) ? 0 : 3,
                  $urandom_range(0, 4) == 0);
      // receiver backs off while the sender keeps offering, so the input stalls
      if (phase == 0 || $urandom_range(0, 7) == 0) hold_asks++;
      for (int i = 0; i < n; i++)
        push_word(pick_word(), pick_word(), $urandom_range(0, 1));
      total += n;
      phase++;
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gfrmx_pkg.sv
hdl/gfrmx_lane.sv
hdl/gfrmx_merge.sv
hdl/gf_region_multiply_xor_core.sv
tb/gf_region_multiply_xor_core_tb.sv
